FILE: rtl/text_console_char_engine_assert.svh
// Assertion macros used by the text console character engine RTL.
// No dependencies; included inside the datapath module body that checks its logic.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TCCE_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("text console engine check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TCCE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("text console engine check failed");

`endif

FILE: rtl/tcce_pkg.sv
// Shared constants, types and the microcode table of the text console engine.
// No dependencies; imported by the sequencer, the datapath and the top level.
package tcce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int OP_W   = 2;
  localparam int STEP_W = 4;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] BS_CODE    = 8'h08;
  localparam logic [CHAR_W-1:0] TAB_CODE   = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CODE    = 8'h0D;
  localparam logic [CHAR_W-1:0] LF_CODE    = 8'h0A;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [COL_W-1:0]  PROMPT_GUARD = 7'd6;

  // Register index decoded from the APB word address.
  localparam logic REG_ATTR = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT, OP_PROMPT, OP_CLEAR, OP_READ
  } op_t;

  typedef enum logic [1:0] {
    WSEL_NONE, WSEL_INIT, WSEL_COPY, WSEL_BLANK
  } wsel_t;

  typedef enum logic [1:0] {
    RSEL_NONE, RSEL_COPY, RSEL_AHEAD, RSEL_CELL
  } rsel_t;

  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_DISPATCH, COND_NO_SCROLL,
    COND_NOT_END_ALL, COND_NOT_END_COPY
  } cond_t;

  typedef enum logic [STEP_W-1:0] {
    ST_INIT, ST_IDLE, ST_PUT, ST_COPY_PRIME, ST_COPY, ST_TAIL, ST_DONE,
    ST_PROMPT, ST_CLEAR, ST_HOME, ST_READ, ST_CAPTURE
  } step_t;

  typedef struct packed {
    logic  in_rdy;
    logic  ptr_clr;
    logic  ptr_inc;
    wsel_t wsel;
    rsel_t rsel;
    logic  put_en;
    logic  lb_clr;
    logic  cur_clr;
    logic  word_load;
    logic  out_load;
    logic  wait_out;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    op_t  op;
    logic need_scroll;
    logic end_all;
    logic end_copy;
    logic out_busy;
  } stat_t;

  // Microcode ROM: one control word per step. A conditional step jumps to
  // its target when the condition holds, else falls through (IDLE waits).
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '0;
    c.cond   = COND_NEVER;
    c.target = ST_IDLE;
    case (s)
      ST_INIT: begin
        c.wsel = WSEL_INIT; c.ptr_inc = 1'b1;
        c.cond = COND_NOT_END_ALL; c.target = ST_INIT;
      end
      ST_IDLE: begin
        c.ptr_clr = 1'b1; c.in_rdy = 1'b1; c.cond = COND_DISPATCH;
      end
      ST_PUT: begin
        c.put_en = 1'b1; c.cond = COND_NO_SCROLL; c.target = ST_DONE;
      end
      ST_COPY_PRIME: begin
        c.rsel = RSEL_COPY;
      end
      ST_COPY: begin
        c.wsel = WSEL_COPY; c.rsel = RSEL_AHEAD; c.ptr_inc = 1'b1;
        c.cond = COND_NOT_END_COPY; c.target = ST_COPY;
      end
      ST_TAIL: begin
        c.wsel = WSEL_BLANK; c.ptr_inc = 1'b1;
        c.cond = COND_NOT_END_ALL; c.target = ST_TAIL;
      end
      ST_DONE: begin
        c.out_load = 1'b1; c.wait_out = 1'b1;
        c.cond = COND_ALWAYS; c.target = ST_IDLE;
      end
      ST_PROMPT: begin
        c.lb_clr = 1'b1; c.cond = COND_ALWAYS; c.target = ST_DONE;
      end
      ST_CLEAR: begin
        c.wsel = WSEL_BLANK; c.ptr_inc = 1'b1;
        c.cond = COND_NOT_END_ALL; c.target = ST_CLEAR;
      end
      ST_HOME: begin
        c.cur_clr = 1'b1; c.cond = COND_ALWAYS; c.target = ST_DONE;
      end
      ST_READ: begin
        c.rsel = RSEL_CELL;
      end
      ST_CAPTURE: begin
        c.word_load = 1'b1; c.cond = COND_ALWAYS; c.target = ST_DONE;
      end
      default: begin
        c.cond = COND_ALWAYS; c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic step_t dispatch(op_t op);
    step_t s;
    case (op)
      OP_PUT:    s = ST_PUT;
      OP_PROMPT: s = ST_PROMPT;
      OP_CLEAR:  s = ST_CLEAR;
      OP_READ:   s = ST_READ;
      default:   s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/tcce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the screen buffer.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tcce_useq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on tcce_pkg for the control word, status and step types.
module tcce_useq (
  input  logic            clk,
  input  logic            rst,
  input  tcce_pkg::stat_t stat,
  output tcce_pkg::ctrl_t ctrl
);
  import tcce_pkg::*;

  step_t pc;
  step_t pc_next;
  step_t pc_inc;

  assign pc_inc = step_t'(pc + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_INIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    pc_next = pc_inc;
    if (ctrl.wait_out && stat.out_busy) begin
      pc_next = pc;
    end else begin
      case (ctrl.cond)
        COND_NEVER:        pc_next = pc_inc;
        COND_ALWAYS:       pc_next = ctrl.target;
        COND_DISPATCH:     pc_next = stat.accept ? dispatch(stat.op) : pc;
        COND_NO_SCROLL:    pc_next = stat.need_scroll ? pc_inc : ctrl.target;
        COND_NOT_END_ALL:  pc_next = stat.end_all ? pc_inc : ctrl.target;
        COND_NOT_END_COPY: pc_next = stat.end_copy ? pc_inc : ctrl.target;
        default:           pc_next = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl = ucode(pc);
  end

endmodule

FILE: rtl/tcce_dp.sv
// Datapath: cursor and flag registers, character decode, walk pointer,
// screen RAM and the result register. Depends on tcce_pkg and tcce_ram.
module tcce_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  tcce_pkg::ctrl_t              ctrl,
  output tcce_pkg::stat_t              stat,
  input  logic [tcce_pkg::ATTR_W-1:0]  attribute,
  input  logic                         in_valid,
  input  logic [tcce_pkg::OP_W-1:0]    in_op,
  input  logic [tcce_pkg::CHAR_W-1:0]  in_char,
  input  logic [tcce_pkg::IDX_W-1:0]   in_idx,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcce_pkg::IDX_W-1:0]   out_cursor,
  output logic [tcce_pkg::CELL_W-1:0]  out_word,
  output logic                         out_scrolled
);
  import tcce_pkg::*;

  logic              accept;
  logic              out_free;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic              lb_seen;
  logic [IDX_W-1:0]  ptr;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CELL_W-1:0] word_q;
  logic              scrolled_q;

  logic [IDX_W-1:0]  cur_pos;
  logic [COL_W:0]    tab_sum;
  logic [COL_W:0]    col_w;
  logic [ROW_W-1:0]  row_p;
  logic              lb_set;
  logic              put_we;
  logic [IDX_W-1:0]  put_addr;
  logic [CELL_W-1:0] put_data;
  logic              need_scroll;
  logic [CELL_W-1:0] blank;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [IDX_W:0]    raddr_w;
  logic              ram_re;
  logic [CELL_W-1:0] ram_rdata;

  assign accept   = in_valid && ctrl.in_rdy;
  assign out_free = !out_valid || out_ready;
  assign blank    = {attribute, BLANK_CHAR};
  assign cur_pos  = IDX_W'(cur_row) * IDX_W'(COLUMNS) + IDX_W'(cur_col);
  assign tab_sum  = {1'b0, cur_col} + (COL_W+1)'(8);

  // Character decode for one put step, including column wrap.
  always_comb begin
    col_w    = {1'b0, cur_col};
    row_p    = cur_row;
    lb_set   = 1'b0;
    put_we   = 1'b0;
    put_addr = cur_pos;
    put_data = {attribute, char_q};
    if (char_q == BS_CODE) begin
      if (!(cur_col < PROMPT_GUARD && !lb_seen) && cur_col != '0) begin
        col_w    = {1'b0, cur_col} - (COL_W+1)'(1);
        put_we   = 1'b1;
        put_addr = cur_pos - IDX_W'(1);
        put_data = blank;
      end
    end else if (char_q == TAB_CODE) begin
      col_w = {tab_sum[COL_W:3], 3'b000};
    end else if (char_q == CR_CODE) begin
      col_w  = '0;
      lb_set = 1'b1;
    end else if (char_q == LF_CODE) begin
      col_w  = '0;
      row_p  = cur_row + ROW_W'(1);
      lb_set = 1'b1;
    end else if (char_q >= BLANK_CHAR) begin
      put_we = 1'b1;
      col_w  = {1'b0, cur_col} + (COL_W+1)'(1);
    end
    if (col_w >= (COL_W+1)'(COLUMNS)) begin
      col_w = '0;
      row_p = row_p + ROW_W'(1);
    end
  end

  assign need_scroll = (row_p == ROW_W'(ROWS));

  always_comb begin
    stat.accept      = accept;
    stat.op          = op_t'(in_op);
    stat.need_scroll = need_scroll;
    stat.end_all     = (ptr == IDX_W'(CELLS - 1));
    stat.end_copy    = (ptr == IDX_W'(CELLS - COLUMNS - 1));
    stat.out_busy    = !out_free;
  end

  // Write port: the put step or one of the buffer walks.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = blank;
    if (ctrl.put_en) begin
      ram_we    = put_we;
      ram_waddr = put_addr;
      ram_wdata = put_data;
    end else begin
      case (ctrl.wsel)
        WSEL_INIT: begin
          ram_we    = 1'b1;
          ram_wdata = {ATTR_RESET, BLANK_CHAR};
        end
        WSEL_COPY: begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
        WSEL_BLANK: begin
          ram_we = 1'b1;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  // The scroll copy reads one line ahead of the cell it writes.
  always_comb begin
    case (ctrl.rsel)
      RSEL_COPY:  raddr_w = {1'b0, ptr} + (IDX_W+1)'(COLUMNS);
      RSEL_AHEAD: raddr_w = {1'b0, ptr} + (IDX_W+1)'(COLUMNS + 1);
      RSEL_CELL:  raddr_w = {1'b0, idx_q};
      default:    raddr_w = '0;
    endcase
    ram_re = (ctrl.rsel != RSEL_NONE) && (raddr_w < (IDX_W+1)'(CELLS));
  end

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (raddr_w[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      lb_seen    <= 1'b0;
      ptr        <= '0;
      word_q     <= '0;
      scrolled_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.ptr_clr) begin
        ptr <= '0;
      end else if (ctrl.ptr_inc) begin
        ptr <= ptr + IDX_W'(1);
      end
      if (accept) begin
        word_q     <= '0;
        scrolled_q <= 1'b0;
      end
      if (ctrl.put_en) begin
        cur_col    <= col_w[COL_W-1:0];
        cur_row    <= need_scroll ? ROW_W'(ROWS - 1) : row_p;
        lb_seen    <= lb_seen || lb_set;
        scrolled_q <= need_scroll;
      end
      if (ctrl.lb_clr) begin
        lb_seen <= 1'b0;
      end
      if (ctrl.cur_clr) begin
        cur_col <= '0;
        cur_row <= '0;
      end
      if (ctrl.word_load) begin
        word_q <= (idx_q < IDX_W'(CELLS)) ? ram_rdata : '0;
      end
      if (ctrl.out_load && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_q <= in_char;
      idx_q  <= in_idx;
    end
    if (ctrl.out_load && out_free) begin
      out_cursor   <= cur_pos;
      out_word     <= word_q;
      out_scrolled <= scrolled_q;
    end
  end

  `include "text_console_char_engine_assert.svh"

  `TCCE_ASSERT_IMP(a_cursor_in_range, clk, rst, ctrl.in_rdy, (cur_row < ROW_W'(ROWS)) && (cur_col < COL_W'(COLUMNS)))
  `TCCE_ASSERT_IMP(a_copy_below_tail, clk, rst, ctrl.wsel == WSEL_COPY, ptr < IDX_W'(CELLS - COLUMNS))
  `TCCE_ASSERT_NEXT(a_result_loaded, clk, rst, ctrl.out_load && out_free, out_valid)

endmodule

FILE: rtl/text_console_char_engine.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata[1:0] op, [9:2] char_code, [20:10] cell_index
// m_axis    out  tdata[10:0] cursor_index, [26:11] cell_word, [27] scrolled
// apb       in   register 0 at byte address 0: attribute[7:0]
//
// Put character and prompt start: the PUT or PROMPT step runs, then DONE registers
// the result beat; read runs READ and CAPTURE before DONE. A new beat is taken only
// in IDLE, after DONE. Scroll and clear walk the screen RAM one cell per cycle through
// its single write port: a scroll runs COPY_PRIME, COPY and TAIL, a clear CLEAR and HOME.
// After reset the sequencer sweeps all 2000 cells to blank before s_axis_tready
// rises. A stalled result holds the sequencer until m_axis_tready frees it.
//
// Top level of the text console character engine; depends on tcce_pkg,
// tcce_useq and tcce_dp.
module text_console_char_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op, char_code, cell_index, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cursor_index, cell_word, scrolled, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcce_pkg::*;

  ctrl_t             ctrl;
  stat_t             stat;
  logic [ATTR_W-1:0] attribute;
  logic [IDX_W-1:0]  cursor_index;
  logic [CELL_W-1:0] cell_word;
  logic              scrolled;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTR) begin
      attribute <= pwdata[ATTR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ATTR) ? {(32-ATTR_W)'(0), attribute} : '0;

  tcce_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  tcce_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .attribute    (attribute),
    .in_valid     (s_axis_tvalid),
    .in_op        (s_axis_tdata[1:0]),
    .in_char      (s_axis_tdata[9:2]),
    .in_idx       (s_axis_tdata[20:10]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_cursor   (cursor_index),
    .out_word     (cell_word),
    .out_scrolled (scrolled)
  );

  assign s_axis_tready = ctrl.in_rdy;
  assign m_axis_tdata  = {4'b0000, scrolled, cell_word, cursor_index};

endmodule

FILE: test/text_console_char_engine_tb.sv
// Self-checking testbench for text_console_char_engine: a stream driver and a monitor,
// a shadow model of the screen buffer and cursor, and APB writes of the attribute.
// Depends on tcce_pkg and the text_console_char_engine RTL only.
`timescale 1ns / 1ps

module text_console_char_engine_tb;
  import tcce_pkg::*;

  // Attribute register sits at word 0 of the APB space.
  localparam logic [2:0] ATTR_ADDR = {REG_ATTR, 2'b00};
  // A scroll or a clear walks the whole screen buffer. Even if every beat of the run
  // scrolled under back-pressure, this limit would still be several times enough.
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 275;

  typedef struct packed {
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] char_code;
    op_t               op;
  } console_cmd_t;

  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_word;
    logic [IDX_W-1:0]  cursor_index;
  } console_res_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // op, char_code, cell_index, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // cursor_index, cell_word, scrolled, zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow state of the console.
  logic [CELL_W-1:0] screen_image [CELLS];
  logic [COL_W-1:0]  cur_col = '0;
  logic [ROW_W-1:0]  cur_row = '0;
  logic              break_seen = 1'b0;
  logic [ATTR_W-1:0] attr_shadow = ATTR_RESET;

  console_cmd_t cmd_backlog[$];
  console_res_t predicted_results[$];
  console_cmd_t on_offer;
  int tx_idle_pct = 29;
  int rx_idle_pct = 29;
  int mismatch_count = 0;
  int result_count = 0;
  int hold_left = 0;
  int cycle_count = 0;

  text_console_char_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_image[i] = {ATTR_RESET, BLANK_CHAR};
  end

  // Applies one accepted command to the shadow console and returns its result.
  function automatic console_res_t console_step(console_cmd_t c);
    console_res_t r;
    logic [CELL_W-1:0] blank;
    r = '0;
    blank = {attr_shadow, BLANK_CHAR};
    case (c.op)
      OP_PUT: begin
        if (c.char_code == BS_CODE) begin
          if (cur_col != 0 && !(cur_col < PROMPT_GUARD && !break_seen)) begin
            cur_col = cur_col - 1'b1;
            screen_image[cur_row * COLUMNS + cur_col] = blank;
          end
        end else if (c.char_code == TAB_CODE) begin
          cur_col = (cur_col + 7'd8) & 7'h78;
        end else if (c.char_code == CR_CODE) begin
          cur_col = '0;
          break_seen = 1'b1;
        end else if (c.char_code == LF_CODE) begin
          cur_col = '0;
          cur_row = cur_row + 1'b1;
          break_seen = 1'b1;
        end else if (c.char_code >= BLANK_CHAR) begin
          screen_image[cur_row * COLUMNS + cur_col] = {attr_shadow, c.char_code};
          cur_col = cur_col + 1'b1;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = '0;
          cur_row = cur_row + 1'b1;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_image[i] = screen_image[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_image[i] = blank;
          cur_row = ROW_W'(ROWS - 1);
          r.scrolled = 1'b1;
        end
      end
      OP_PROMPT: break_seen = 1'b0;
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_image[i] = blank;
        cur_col = '0;
        cur_row = '0;
      end
      OP_READ: begin
        if (c.cell_index < CELLS) r.cell_word = screen_image[c.cell_index];
      end
    endcase
    r.cursor_index = IDX_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  // Driver: predicts each beat as it is accepted, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predicted_results.push_back(console_step(on_offer));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_offer = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'b000, on_offer};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats in order and applies back-pressure.
  always @(posedge clk) begin
    console_res_t got;
    console_res_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[27:0];
        result_count++;
        // Twice in the run the receiver stops long enough for the engine to back up.
        if (result_count == 300 || result_count == 1000) hold_left = 600;
        if (predicted_results.size() == 0) begin
          $error("result beat 0x%h with no result expected", got);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (got.cursor_index !== want.cursor_index) begin
            $error("cursor_index expected %0d actual %0d", want.cursor_index, got.cursor_index);
            mismatch_count++;
          end
          if (got.cell_word !== want.cell_word) begin
            $error("cell_word expected 0x%h actual 0x%h", want.cell_word, got.cell_word);
            mismatch_count++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("scrolled expected %0d actual %0d", want.scrolled, got.scrolled);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [ATTR_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ATTR_ADDR;
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    attr_shadow = value;
  endtask

  task automatic queue_cmd(input op_t op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    console_cmd_t c;
    c.op = op;
    c.char_code = ch;
    c.cell_index = idx;
    cmd_backlog.push_back(c);
  endtask

  // Returns once every command has been accepted and every result checked.
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    console_cmd_t c;
    int roll;
    logic [ATTR_W-1:0] attr_value;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // The engine blanks its buffer after reset; the register write is taken meanwhile.
    reg_write(8'h00);
    @(negedge clk);

    queue_cmd(OP_READ, 8'h00, 11'd0);
    queue_cmd(OP_PUT, BS_CODE, 11'd0);       // backspace at column 0
    queue_cmd(OP_PUT, BLANK_CHAR, 11'd0);
    queue_cmd(OP_PUT, 8'hFF, 11'h7FF);
    queue_cmd(OP_PUT, BS_CODE, 11'd0);       // inside the prompt guard, no line break yet
    queue_cmd(OP_PUT, 8'h00, 11'd0);         // ignored control codes
    queue_cmd(OP_PUT, 8'h1F, 11'd0);
    queue_cmd(OP_PUT, TAB_CODE, 11'd0);
    queue_cmd(OP_PUT, BS_CODE, 11'd0);       // past the guard, blanks column 7
    queue_cmd(OP_PUT, CR_CODE, 11'd0);
    queue_cmd(OP_PUT, 8'h7F, 11'd0);
    queue_cmd(OP_PUT, BS_CODE, 11'd0);       // guard lifted by the carriage return
    queue_cmd(OP_PROMPT, 8'hFF, 11'd0);
    queue_cmd(OP_READ, 8'h00, 11'd1);
    queue_cmd(OP_READ, 8'h00, 11'd7);
    queue_cmd(OP_READ, 8'hFF, 11'd1999);
    queue_cmd(OP_READ, 8'h00, 11'h7FF);      // out of range reads as zero
    queue_cmd(OP_PUT, LF_CODE, 11'd0);
    // Ten tabs run the cursor off the right edge and wrap it.
    for (int i = 0; i < 10; i++) queue_cmd(OP_PUT, TAB_CODE, 11'd0);
    queue_cmd(OP_CLEAR, 8'h00, 11'd0);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) attr_value = 8'hFF;
      else if (phase == 3) attr_value = 8'h00;
      else attr_value = ATTR_W'($urandom_range(255));
      reg_write(attr_value);
      @(negedge clk);
      tx_idle_pct = (phase == 1) ? 0 : 29;
      rx_idle_pct = (phase == 1) ? 0 : 29;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        c.cell_index = IDX_W'($urandom_range(2047));
        c.char_code = CHAR_W'($urandom_range(255));
        roll = $urandom_range(999);
        if (roll < 6) begin
          c.op = OP_CLEAR;
        end else if (roll < 86) begin
          c.op = OP_PROMPT;
        end else if (roll < 186) begin
          c.op = OP_READ;
          if ($urandom_range(99) < 85) c.cell_index = IDX_W'($urandom_range(CELLS - 1));
          else c.cell_index = IDX_W'($urandom_range(2047, CELLS));
        end else begin
          // Mostly text, with enough line feeds to reach the bottom and scroll.
          c.op = OP_PUT;
          roll = $urandom_range(99);
          if (roll < 60) c.char_code = CHAR_W'($urandom_range(255, 32));
          else if (roll < 72) c.char_code = LF_CODE;
          else if (roll < 75) c.char_code = CR_CODE;
          else if (roll < 80) c.char_code = TAB_CODE;
          else if (roll < 90) c.char_code = BS_CODE;
          else c.char_code = CHAR_W'($urandom_range(31));
        end
        cmd_backlog.push_back(c);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
